>>> rtl/core/rpld_pkg.sv
// Package: item types, codes, constants and the distance ROM function for the lock detector.
package rpld_pkg;

	localparam int ROM_Q = 24;
	localparam int ROM_ZERO = 197;
	localparam logic [63:0] MUL_UP = 64'd1177334498;
	localparam logic [63:0] MUL_DN = 64'd979264182;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_LOCK = 2'd1;
	localparam logic [1:0] ACT_UNLOCK = 2'd2;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_SLOW = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_QUICK = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOCK_DISTANCE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNLOCK_DISTANCE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GRACE_TICKS = 3'd5;

	localparam logic [8:0] ALPHA_ONE = 9'd256;

	typedef struct packed {
		logic              cmd;
		logic signed [7:0] rssi;
		logic              host_connected;
	} req_t;

	typedef struct packed {
		logic [15:0] distance;
		logic [1:0]  action;
		logic        locked;
		logic        timed_out;
	} rsp_t;

	typedef struct packed {
		logic [8:0]  alpha_slow;
		logic [8:0]  alpha_quick;
		logic [15:0] jump_threshold;
	} ema_cfg_t;

	// ROM entry for one rssi byte: 10^((-70 - rssi)/25) in fixed point, frac fraction bits
	function automatic logic [15:0] dist_entry(input int frac, input int rb);
		int s;
		int k;
		int sh;
		logic [63:0] v;
		logic [63:0] r;
		s = (rb < 128) ? rb : rb - 256;
		k = 127 - s;
		sh = ROM_Q - frac;
		v = 64'd1 << ROM_Q;
		if (k > ROM_ZERO) begin
			for (int i = 0; i < k - ROM_ZERO; i++) begin
				v = (v * MUL_UP) >> 30;
			end
		end else begin
			for (int i = 0; i < ROM_ZERO - k; i++) begin
				v = (v * MUL_DN) >> 30;
			end
		end
		r = (v + (64'd1 << (sh - 1))) >> sh;
		return (r > 64'hFFFF) ? 16'hFFFF : r[15:0];
	endfunction

endpackage

>>> rtl/core/rpld_ema.sv
// Adaptive EMA step: weight pick by jump size, weighted blend, round and saturate.
module rpld_ema (
	input  logic [15:0]        raw,
	input  logic [15:0]        filt,
	input  rpld_pkg::ema_cfg_t cfg,
	output logic [15:0]        blended
);
	import rpld_pkg::*;

	logic [15:0] diff;
	logic [8:0]  sel;
	logic [8:0]  a;
	logic [8:0]  w;
	logic [24:0] acc;

	always_comb begin
		diff = (raw > filt) ? raw - filt : filt - raw;
		sel = (diff > cfg.jump_threshold) ? cfg.alpha_quick : cfg.alpha_slow;
		a = (sel > ALPHA_ONE) ? ALPHA_ONE : sel;
		w = ALPHA_ONE - a;
		acc = 25'(a) * 25'(raw) + 25'(w) * 25'(filt) + 25'd128;
		blended = acc[24] ? 16'hFFFF : acc[23:8];
	end

endmodule

>>> rtl/core/rssi_proximity_lock_detector.sv
// Top level: RSSI proximity lock detector with distance ROM, adaptive EMA and hysteresis.
//
// Each request is an RSSI sample or a time tick and yields exactly one response.
// A request is held in the input register; the ROM lookup, EMA blend, timeout and lock
// decision are then done combinationally from it and land in the response register, so
// a new request is taken every cycle while the response side keeps up. The distance ROM
// is a 256-entry constant table built at elaboration for FRAC_BITS fraction bits.
// Configuration writes are always ready and take effect on the next request; write
// only while the block is idle.
module rssi_proximity_lock_detector #(
	parameter int FRAC_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  rpld_pkg::req_t                   req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output rpld_pkg::rsp_t                   rsp,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rpld_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [15:0]                      cfg_data
);
	import rpld_pkg::*;

	localparam int JUMP_INT = 3 << (FRAC_BITS - 1);
	localparam int LOCK_INT = 2 << FRAC_BITS;
	localparam int FAR_INT = 10 << FRAC_BITS;
	localparam logic [15:0] JUMP_RST = (JUMP_INT > 65535) ? 16'hFFFF : 16'(JUMP_INT);
	localparam logic [15:0] LOCK_RST = (LOCK_INT > 65535) ? 16'hFFFF : 16'(LOCK_INT);
	localparam logic [15:0] FAR_DIST = (FAR_INT > 65535) ? 16'hFFFF : 16'(FAR_INT);

	logic [15:0] rom_w [256];

	for (genvar g = 0; g < 256; g++) begin : g_rom
		localparam logic [15:0] ENTRY = dist_entry(FRAC_BITS, g);
		assign rom_w[g] = ENTRY;
	end

	ema_cfg_t    ema_cfg_q;
	logic [15:0] lock_dist_q;
	logic [15:0] unlock_dist_q;
	logic [15:0] grace_q;

	logic        valid_s1;
	req_t        req_s1;

	logic [15:0] filt_q;
	logic        lock_q;
	logic        timeout_q;
	logic [15:0] ticks_q;

	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic        advance;
	logic [7:0]  rbyte;
	logic [15:0] raw;
	logic [15:0] blended;
	logic [15:0] filt_n;
	logic        timeout_n;
	logic [15:0] ticks_n;
	logic        lock_n;
	logic [1:0]  action_n;

	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ema_cfg_q.alpha_slow <= 9'd13;
			ema_cfg_q.alpha_quick <= 9'd64;
			ema_cfg_q.jump_threshold <= JUMP_RST;
			lock_dist_q <= LOCK_RST;
			unlock_dist_q <= JUMP_RST;
			grace_q <= 16'd60;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ALPHA_SLOW: ema_cfg_q.alpha_slow <= cfg_data[8:0];
				REG_ALPHA_QUICK: ema_cfg_q.alpha_quick <= cfg_data[8:0];
				REG_JUMP_THRESHOLD: ema_cfg_q.jump_threshold <= cfg_data;
				REG_LOCK_DISTANCE: lock_dist_q <= cfg_data;
				REG_UNLOCK_DISTANCE: unlock_dist_q <= cfg_data;
				REG_GRACE_TICKS: grace_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rbyte = req_s1.rssi;
	assign raw = rom_w[rbyte];

	rpld_ema u_ema (
		.raw     (raw),
		.filt    (filt_q),
		.cfg     (ema_cfg_q),
		.blended (blended)
	);

	always_comb begin
		filt_n = filt_q;
		timeout_n = timeout_q;
		ticks_n = ticks_q;
		if (req_s1.cmd == CMD_SAMPLE) begin
			ticks_n = 16'd0;
			if (filt_q == 16'd0 || timeout_q) begin
				filt_n = raw;
				timeout_n = 1'b0;
			end else begin
				filt_n = blended;
			end
		end else begin
			ticks_n = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
			if (ticks_n > grace_q) begin
				filt_n = FAR_DIST;
				timeout_n = 1'b1;
			end
		end

		lock_n = lock_q;
		action_n = ACT_NONE;
		if (req_s1.host_connected) begin
			if (filt_n > lock_dist_q && !lock_q) begin
				lock_n = 1'b1;
				action_n = ACT_LOCK;
			end else if (filt_n < unlock_dist_q && lock_q) begin
				lock_n = 1'b0;
				action_n = ACT_UNLOCK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			filt_q <= 16'd0;
			lock_q <= 1'b0;
			timeout_q <= 1'b0;
			ticks_q <= 16'd0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				filt_q <= filt_n;
				lock_q <= lock_n;
				timeout_q <= timeout_n;
				ticks_q <= ticks_n;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_q.distance <= filt_n;
			rsp_q.action <= action_n;
			rsp_q.locked <= lock_n;
			rsp_q.timed_out <= timeout_n;
		end
	end

	a_lock_sets: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.action == ACT_LOCK |-> rsp_q.locked)
		else $error("lock action without locked state");

	a_unlock_clears: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.action == ACT_UNLOCK |-> !rsp_q.locked)
		else $error("unlock action with locked state");

	a_timeout_far: assert property (@(posedge clk) disable iff (!arst_n)
		timeout_q |-> filt_q == FAR_DIST)
		else $error("timeout flag set but distance not forced far");

	a_advance_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid_q)
		else $error("processed request produced no response");

endmodule
